@@ rtl/sbs_pkg.sv @@
`timescale 1ns / 1ps
// sbs_pkg: shared types, constants and helpers for the sudoku solver.
// No dependencies; imported by every module of the block.
package sbs_pkg;

  localparam int N_COLS       = 9;
  localparam int CELL_W       = 4;
  localparam int IDX_W        = 4;
  localparam int MAX_VAL      = 9;
  localparam int OVERFLOW_VAL = 10;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_COLS - 1);

  // One stored grid row: cell values and the given flags.
  typedef struct packed {
    logic [N_COLS-1:0]             given;
    logic [N_COLS-1:0][CELL_W-1:0] val;
  } row_t;

  // Update command broadcast to the three constraint lanes.
  typedef struct packed {
    logic              clr;
    logic              set;
    logic              unset;
    logic [CELL_W-1:0] val;
  } lane_op_t;

  // Value 1..9 to its bit in a used-set word; anything else maps to no bit.
  function automatic logic [N_COLS-1:0] val_bit(input logic [CELL_W-1:0] v);
    logic [N_COLS-1:0] b;
    b = '0;
    if (v >= CELL_W'(1) && v <= CELL_W'(MAX_VAL)) begin
      b = N_COLS'(1) << (v - CELL_W'(1));
    end
    return b;
  endfunction

  // 3x3 box number of a cell, as a small table rather than a divide.
  function automatic logic [IDX_W-1:0] box_of(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
    logic [IDX_W-1:0] br;
    logic [IDX_W-1:0] bc;
    case (r)
      4'd0, 4'd1, 4'd2: br = 4'd0;
      4'd3, 4'd4, 4'd5: br = 4'd3;
      default:          br = 4'd6;
    endcase
    case (c)
      4'd0, 4'd1, 4'd2: bc = 4'd0;
      4'd3, 4'd4, 4'd5: bc = 4'd1;
      default:          bc = 4'd2;
    endcase
    return br + bc;
  endfunction

endpackage

@@ rtl/sbs_lane.sv @@
`timescale 1ns / 1ps
// sbs_lane: one constraint lane, a used-value set for each of nine units
// (rows, columns or boxes). Depends on sbs_pkg.
module sbs_lane import sbs_pkg::*; (
  input  logic              clk,
  input  lane_op_t          op,
  input  logic [IDX_W-1:0]  idx,
  output logic [N_COLS-1:0] used
);

  logic [N_COLS-1:0] word [N_COLS];

  always_ff @(posedge clk) begin
    if (op.clr) begin
      for (int i = 0; i < N_COLS; i++) begin
        word[i] <= '0;
      end
    end else if (op.set) begin
      word[idx] <= word[idx] | val_bit(op.val);
    end else if (op.unset) begin
      word[idx] <= word[idx] & ~val_bit(op.val);
    end
  end

  assign used = word[idx];

endmodule

@@ rtl/sbs_merge.sv @@
`timescale 1ns / 1ps
// sbs_merge: combines the row, column and box lanes into one verdict
// for the candidate value. Depends on sbs_pkg.
module sbs_merge import sbs_pkg::*; (
  input  logic [N_COLS-1:0] row_used,
  input  logic [N_COLS-1:0] col_used,
  input  logic [N_COLS-1:0] box_used,
  input  logic [CELL_W-1:0] cand,
  output logic              free
);

  logic [N_COLS-1:0] any_used;

  assign any_used = row_used | col_used | box_used;

  // out-of-range candidates are never free
  assign free = |val_bit(cand) && ((any_used & val_bit(cand)) == '0);

endmodule

@@ rtl/sudoku_backtrack_solver.sv @@
`timescale 1ns / 1ps
// sudoku_backtrack_solver: top level, row store, search sequencer and lanes.
// Depends on sbs_pkg, sbs_lane and sbs_merge.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  in      | in_c0..in_c8 (4b each)                  | start & !busy takes a row
//  out     | out_c0..out_c8, status, last_row        | strobe, one cycle, no stall
//
// After the ninth row the block is busy building the lane sets from the
// givens (all 81 cells, each row fetched from the store), then for the
// search: at each empty cell it tests candidate values in turn, givens are
// skipped, and each row change writes back one row and fetches another.
// Search length depends on the puzzle. Each result row is read from the
// store, then strobed.
// Reset is synchronous and returns the block to waiting for row one. The
// receiver cannot stall, so results go out on a fixed schedule.
module sudoku_backtrack_solver import sbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CELL_W-1:0] in_c0,
  input  logic [CELL_W-1:0] in_c1,
  input  logic [CELL_W-1:0] in_c2,
  input  logic [CELL_W-1:0] in_c3,
  input  logic [CELL_W-1:0] in_c4,
  input  logic [CELL_W-1:0] in_c5,
  input  logic [CELL_W-1:0] in_c6,
  input  logic [CELL_W-1:0] in_c7,
  input  logic [CELL_W-1:0] in_c8,
  output logic              strobe,
  output logic [CELL_W-1:0] out_c0,
  output logic [CELL_W-1:0] out_c1,
  output logic [CELL_W-1:0] out_c2,
  output logic [CELL_W-1:0] out_c3,
  output logic [CELL_W-1:0] out_c4,
  output logic [CELL_W-1:0] out_c5,
  output logic [CELL_W-1:0] out_c6,
  output logic [CELL_W-1:0] out_c7,
  output logic [CELL_W-1:0] out_c8,
  output logic              status,
  output logic              last_row
);

  // sequencer states
  localparam logic [3:0] S_LOAD  = 4'd0;  // idle, taking rows
  localparam logic [3:0] S_FETCH = 4'd1;  // read row r from the store
  localparam logic [3:0] S_GRAB  = 4'd2;  // copy read data into the work row
  localparam logic [3:0] S_PREP  = 4'd3;  // enter givens into the lanes
  localparam logic [3:0] S_CELL  = 4'd4;  // cursor arrives at a cell
  localparam logic [3:0] S_TRY   = 4'd5;  // test one candidate value
  localparam logic [3:0] S_EREAD = 4'd6;  // read a solved row
  localparam logic [3:0] S_EOUT  = 4'd7;  // present a solved row
  localparam logic [3:0] S_FAIL  = 4'd8;  // present the no-solution result

  logic [3:0]        state, state_next;
  logic [IDX_W-1:0]  rows_loaded, rows_loaded_next;
  logic [IDX_W-1:0]  r, r_next;
  logic [IDX_W-1:0]  c, c_next;
  logic              backing_up, backing_up_next;
  logic              searching, searching_next;
  logic [CELL_W-1:0] cand, cand_next;
  row_t              work, work_next;

  // row store: nine rows, one write and one registered read per cycle
  row_t              grid [N_COLS];
  row_t              row_q;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [IDX_W-1:0]  ra;
  row_t              wd;
  row_t              in_row;

  // lanes
  lane_op_t          op;
  logic [N_COLS-1:0] row_used, col_used, box_used;
  logic              free;
  logic              step_fwd, step_back;

  logic [CELL_W-1:0] cur_val;
  logic              cur_given;

  assign cur_val   = work.val[c];
  assign cur_given = work.given[c];

  always_comb begin
    in_row.val = {in_c8, in_c7, in_c6, in_c5, in_c4, in_c3, in_c2, in_c1, in_c0};
    for (int j = 0; j < N_COLS; j++) begin
      in_row.given[j] = (in_row.val[j] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      grid[wa] <= wd;
    end
    row_q <= grid[ra];
  end

  sbs_lane u_row_lane (.clk(clk), .op(op), .idx(r),            .used(row_used));
  sbs_lane u_col_lane (.clk(clk), .op(op), .idx(c),            .used(col_used));
  sbs_lane u_box_lane (.clk(clk), .op(op), .idx(box_of(r, c)), .used(box_used));

  sbs_merge u_merge (
    .row_used(row_used),
    .col_used(col_used),
    .box_used(box_used),
    .cand    (cand),
    .free    (free)
  );

  always_comb begin
    state_next       = state;
    rows_loaded_next = rows_loaded;
    r_next           = r;
    c_next           = c;
    backing_up_next  = backing_up;
    searching_next   = searching;
    cand_next        = cand;
    work_next        = work;
    we               = 1'b0;
    wa               = r;
    wd               = work;
    ra               = r;
    op               = '0;
    step_fwd         = 1'b0;
    step_back        = 1'b0;

    case (state)
      S_LOAD: begin
        if (start) begin
          we = 1'b1;
          wa = rows_loaded;
          wd = in_row;
          if (rows_loaded == LAST_IDX) begin
            // full grid in: clear the lanes and start the given sweep
            rows_loaded_next = '0;
            op.clr           = 1'b1;
            r_next           = '0;
            c_next           = '0;
            searching_next   = 1'b0;
            state_next       = S_FETCH;
          end else begin
            rows_loaded_next = rows_loaded + IDX_W'(1);
          end
        end
      end
      S_FETCH: begin
        state_next = S_GRAB;
      end
      S_GRAB: begin
        work_next  = row_q;
        state_next = searching ? S_CELL : S_PREP;
      end
      S_PREP: begin
        // givens of 10..15 never match a candidate, so they stay out
        if (cur_given && cur_val <= CELL_W'(MAX_VAL)) begin
          op.set = 1'b1;
          op.val = cur_val;
        end
        if (c == LAST_IDX) begin
          c_next     = '0;
          state_next = S_FETCH;
          if (r == LAST_IDX) begin
            r_next          = '0;
            searching_next  = 1'b1;
            backing_up_next = 1'b0;
          end else begin
            r_next = r + IDX_W'(1);
          end
        end else begin
          c_next = c + IDX_W'(1);
        end
      end
      S_CELL: begin
        if (cur_given) begin
          step_fwd  = !backing_up;
          step_back = backing_up;
        end else begin
          // a nonzero value here was placed earlier: take it out of the lanes
          backing_up_next = 1'b0;
          if (cur_val != '0) begin
            op.unset = 1'b1;
            op.val   = cur_val;
          end
          cand_next  = cur_val + CELL_W'(1);
          state_next = S_TRY;
        end
      end
      S_TRY: begin
        if (cand == CELL_W'(OVERFLOW_VAL)) begin
          work_next.val[c] = '0;
          backing_up_next  = 1'b1;
          step_back        = 1'b1;
        end else if (free) begin
          work_next.val[c] = cand;
          op.set           = 1'b1;
          op.val           = cand;
          step_fwd         = 1'b1;
        end else begin
          cand_next = cand + CELL_W'(1);
        end
      end
      S_EREAD: begin
        state_next = S_EOUT;
      end
      S_EOUT: begin
        if (r == LAST_IDX) begin
          r_next     = '0;
          state_next = S_LOAD;
        end else begin
          r_next     = r + IDX_W'(1);
          state_next = S_EREAD;
        end
      end
      S_FAIL: begin
        state_next = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase

    // cursor moves; leaving a row writes the work row back to the store
    if (step_fwd) begin
      if (c == LAST_IDX) begin
        we     = 1'b1;
        wd     = work_next;
        c_next = '0;
        if (r == LAST_IDX) begin
          r_next     = '0;
          state_next = S_EREAD;
        end else begin
          r_next     = r + IDX_W'(1);
          state_next = S_FETCH;
        end
      end else begin
        c_next     = c + IDX_W'(1);
        state_next = S_CELL;
      end
    end
    if (step_back) begin
      if (c == '0) begin
        if (r == '0) begin
          state_next = S_FAIL;
        end else begin
          we         = 1'b1;
          wd         = work_next;
          r_next     = r - IDX_W'(1);
          c_next     = LAST_IDX;
          state_next = S_FETCH;
        end
      end else begin
        c_next     = c - IDX_W'(1);
        state_next = S_CELL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      rows_loaded <= '0;
      r           <= '0;
      c           <= '0;
      backing_up  <= 1'b0;
      searching   <= 1'b0;
    end else begin
      state       <= state_next;
      rows_loaded <= rows_loaded_next;
      r           <= r_next;
      c           <= c_next;
      backing_up  <= backing_up_next;
      searching   <= searching_next;
    end
  end

  always_ff @(posedge clk) begin
    cand <= cand_next;
    work <= work_next;
  end

  // result ports
  assign busy     = (state != S_LOAD);
  assign strobe   = (state == S_EOUT) || (state == S_FAIL);
  assign status   = (state == S_FAIL);
  assign last_row = (state == S_FAIL) || ((state == S_EOUT) && (r == LAST_IDX));

  assign out_c0 = (state == S_EOUT) ? row_q.val[0] : '0;
  assign out_c1 = (state == S_EOUT) ? row_q.val[1] : '0;
  assign out_c2 = (state == S_EOUT) ? row_q.val[2] : '0;
  assign out_c3 = (state == S_EOUT) ? row_q.val[3] : '0;
  assign out_c4 = (state == S_EOUT) ? row_q.val[4] : '0;
  assign out_c5 = (state == S_EOUT) ? row_q.val[5] : '0;
  assign out_c6 = (state == S_EOUT) ? row_q.val[6] : '0;
  assign out_c7 = (state == S_EOUT) ? row_q.val[7] : '0;
  assign out_c8 = (state == S_EOUT) ? row_q.val[8] : '0;

endmodule

@@ rtl/sbs_checker.sv @@
`timescale 1ns / 1ps
// sbs_checker: port-level checks on the solver's result transactions,
// bound to sudoku_backtrack_solver. Depends on sbs_pkg.
module sbs_checker import sbs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [CELL_W-1:0] out_c0,
  input logic [CELL_W-1:0] out_c1,
  input logic [CELL_W-1:0] out_c2,
  input logic [CELL_W-1:0] out_c3,
  input logic [CELL_W-1:0] out_c4,
  input logic [CELL_W-1:0] out_c5,
  input logic [CELL_W-1:0] out_c6,
  input logic [CELL_W-1:0] out_c7,
  input logic [CELL_W-1:0] out_c8,
  input logic              status,
  input logic              last_row
);

  // results only come out of a run in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result strobe while idle");

  // no-solution is a single, final transaction
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && status) |-> last_row)
    else $error("no-solution result not marked last");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && status) |-> (out_c0 == '0 && out_c1 == '0 && out_c2 == '0 &&
                            out_c3 == '0 && out_c4 == '0 && out_c5 == '0 &&
                            out_c6 == '0 && out_c7 == '0 && out_c8 == '0))
    else $error("no-solution result carries cell values");

  // the last transaction of a run frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_row) |=> !busy)
    else $error("still busy after final result");

  // a run only begins on an accepted row
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a row being taken");

endmodule

bind sudoku_backtrack_solver sbs_checker u_sbs_checker (.*);

@@ sim/tb_sudoku_backtrack_solver.sv @@
`timescale 1ns / 1ps
// tb_sudoku_backtrack_solver: self-checking testbench for the 9x9 backtracking solver.
// Depends on sbs_pkg and the sudoku_backtrack_solver RTL only; reads no files.
module tb_sudoku_backtrack_solver;
  import sbs_pkg::*;

  localparam int N_CELLS    = N_COLS * N_COLS;
  localparam int BAND_CELLS = 3 * N_COLS;
  // Random grids are kept to searches of at most this many cursor steps.
  localparam int STEP_BUDGET = 10000;
  localparam int WATCHDOG    = 200000;
  localparam int DRAIN       = 40;
  localparam int NO_LIMIT    = 1 << 30;

  localparam logic ST_SOLVED      = 1'b0;
  localparam logic ST_NO_SOLUTION = 1'b1;

  typedef logic [CELL_W-1:0] cell_t;

  // One expected result transaction.
  typedef struct packed {
    logic [N_COLS-1:0][CELL_W-1:0] cells;
    logic                          status;
    logic                          is_last;
  } row_result_t;

  typedef enum {GK_PUZZLE, GK_BROKEN, GK_NOISE} grid_kind_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic strobe;
  logic status;
  logic last_row;
  logic [N_COLS-1:0][CELL_W-1:0] row_bus = '0;
  cell_t out_c0, out_c1, out_c2, out_c3, out_c4, out_c5, out_c6, out_c7, out_c8;
  logic [N_COLS-1:0][CELL_W-1:0] seen_cells;

  assign seen_cells = {out_c8, out_c7, out_c6, out_c5, out_c4,
                       out_c3, out_c2, out_c1, out_c0};

  always #2 clk = ~clk;

  sudoku_backtrack_solver DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_c0   (row_bus[0]),
    .in_c1   (row_bus[1]),
    .in_c2   (row_bus[2]),
    .in_c3   (row_bus[3]),
    .in_c4   (row_bus[4]),
    .in_c5   (row_bus[5]),
    .in_c6   (row_bus[6]),
    .in_c7   (row_bus[7]),
    .in_c8   (row_bus[8]),
    .strobe  (strobe),
    .out_c0  (out_c0),
    .out_c1  (out_c1),
    .out_c2  (out_c2),
    .out_c3  (out_c3),
    .out_c4  (out_c4),
    .out_c5  (out_c5),
    .out_c6  (out_c6),
    .out_c7  (out_c7),
    .out_c8  (out_c8),
    .status  (status),
    .last_row(last_row)
  );

  // ---------------------------------------------------------------------------
  // Testbench state
  // ---------------------------------------------------------------------------
  cell_t       sol_grid  [N_CELLS];  // a valid filled grid
  cell_t       next_grid [N_CELLS];  // grid about to be sent
  cell_t       loaded    [N_CELLS];  // rows as the block took them
  cell_t       work      [N_CELLS];  // search scratch grid
  bit          work_given[N_CELLS];
  int          rows_in      = 0;
  row_result_t solved_rows[$];       // results still owed by the block
  int          errors       = 0;
  int          grids_done   = 0;
  int          solved_grids = 0;
  int          dead_grids   = 0;
  int          rows_checked = 0;
  int          idle_cycles  = 0;
  bit          idle_on      = 1'b0;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Solver prediction
  // ---------------------------------------------------------------------------
  // Does the value at pos clash with anything in its row, column or box?
  function automatic bit cell_fits(input int pos);
    int  row0, col, box, i, j, k;
    bit  ok;
    row0 = (pos / N_COLS) * N_COLS;
    col  = pos % N_COLS;
    box  = (col / 3) * 3 + (pos / BAND_CELLS) * BAND_CELLS;
    ok   = 1'b1;
    for (i = row0; i < row0 + N_COLS; i++)
      if (i != pos && work[i] == work[pos]) ok = 1'b0;
    for (i = col; i < N_CELLS; i += N_COLS)
      if (i != pos && work[i] == work[pos]) ok = 1'b0;
    for (i = 0; i <= 2 * N_COLS; i += N_COLS)
      for (j = 0; j < 3; j++) begin
        k = box + i + j;
        if (k != pos && work[k] == work[pos]) ok = 1'b0;
      end
    return ok;
  endfunction

  // Chronological backtracking over work[]; givens are skipped in the
  // current direction, empty cells are raised until they fit or overflow.
  task automatic backtrack_search(input int limit, output bit found, output bit aborted,
                                  output int steps);
    int cur;
    bit back;
    cur     = 0;
    back    = 1'b0;
    found   = 1'b0;
    aborted = 1'b0;
    steps   = 0;
    while (!found && !aborted && cur >= 0) begin
      if (cur >= N_CELLS) begin
        found = 1'b1;
      end else if (steps >= limit) begin
        aborted = 1'b1;
      end else begin
        steps++;
        if (work_given[cur]) begin
          cur = back ? cur - 1 : cur + 1;
        end else begin
          back      = 1'b0;
          work[cur] = work[cur] + 1'b1;
          if (work[cur] == cell_t'(OVERFLOW_VAL)) begin
            work[cur] = '0;
            cur--;
            back = 1'b1;
          end else if (cell_fits(cur)) begin
            cur++;
          end
        end
      end
    end
  endtask

  // Nine rows are in: solve them and queue what the block must emit.
  task automatic predict_grid();
    bit          found, aborted;
    int          steps, r, c;
    row_result_t res;
    for (c = 0; c < N_CELLS; c++) begin
      work[c]       = loaded[c];
      work_given[c] = (loaded[c] != '0);
    end
    backtrack_search(NO_LIMIT, found, aborted, steps);
    if (!found) begin
      res.cells   = '0;
      res.status  = ST_NO_SOLUTION;
      res.is_last = 1'b1;
      solved_rows.push_back(res);
      dead_grids++;
    end else begin
      for (r = 0; r < N_COLS; r++) begin
        for (c = 0; c < N_COLS; c++) res.cells[c] = work[r * N_COLS + c];
        res.status  = ST_SOLVED;
        res.is_last = (r == N_COLS - 1);
        solved_rows.push_back(res);
      end
      solved_grids++;
    end
    grids_done++;
  endtask

  // Dry run of next_grid to keep random searches short.
  task automatic grid_is_quick(output bit quick);
    bit found, aborted;
    int steps, i;
    for (i = 0; i < N_CELLS; i++) begin
      work[i]       = next_grid[i];
      work_given[i] = (next_grid[i] != '0);
    end
    backtrack_search(STEP_BUDGET, found, aborted, steps);
    quick = !aborted;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Shared driver: one row transaction. Data and start change at the falling
  // edge; busy is stable from there to the next rising edge, so the value
  // held at the falling edge tells whether that rising edge takes the row.
  task automatic send_row(input int row);
    bit hold, taken;
    int gap, j;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    for (j = 0; j < N_COLS; j++) row_bus[j] <= next_grid[row * N_COLS + j];
    start <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      hold = busy;
      @(posedge clk);
      taken = !hold;
      if (!taken) @(negedge clk);
    end
    for (j = 0; j < N_COLS; j++) loaded[rows_in * N_COLS + j] = next_grid[row * N_COLS + j];
    rows_in++;
    if (rows_in == N_COLS) begin
      rows_in = 0;
      predict_grid();
    end
  endtask

  task automatic send_grid();
    int r;
    for (r = 0; r < N_COLS; r++) send_row(r);
  endtask

  // Random valid grid: shuffled digits, rows/cols swapped within bands and
  // stacks, bands swapped, optional transpose of the base pattern.
  task automatic make_solution();
    int digit[N_COLS];
    int rmap [N_COLS];
    int cmap [N_COLS];
    int i, j, m, a, b, r, c, tmp;
    bit flip;
    for (i = 0; i < N_COLS; i++) begin
      digit[i] = i + 1;
      rmap[i]  = i;
      cmap[i]  = i;
    end
    for (i = N_COLS - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = digit[i];
      digit[i] = digit[j];
      digit[j] = tmp;
    end
    repeat (6) begin
      a       = 3 * $urandom_range(0, 2);
      i       = a + $urandom_range(0, 2);
      j       = a + $urandom_range(0, 2);
      tmp     = rmap[i];
      rmap[i] = rmap[j];
      rmap[j] = tmp;
      a       = 3 * $urandom_range(0, 2);
      i       = a + $urandom_range(0, 2);
      j       = a + $urandom_range(0, 2);
      tmp     = cmap[i];
      cmap[i] = cmap[j];
      cmap[j] = tmp;
    end
    a = $urandom_range(0, 2);
    b = $urandom_range(0, 2);
    for (m = 0; m < 3; m++) begin
      tmp             = rmap[3 * a + m];
      rmap[3 * a + m] = rmap[3 * b + m];
      rmap[3 * b + m] = tmp;
    end
    flip = $urandom_range(0, 1);
    for (r = 0; r < N_COLS; r++)
      for (c = 0; c < N_COLS; c++) begin
        i = flip ? cmap[c] : rmap[r];
        j = flip ? rmap[r] : cmap[c];
        sol_grid[r * N_COLS + c] = cell_t'(digit[(i * 3 + i / 3 + j) % N_COLS]);
      end
  endtask

  // Builds next_grid of the given kind, retrying until the search stays within
  // budget (solution-based retries get fewer blanks). Out-of-range givens (10..15) are sprinkled in.
  task automatic build_grid(input grid_kind_t kind);
    bit quick;
    int kmax, tries, k, i, p;
    kmax  = $urandom_range(10, 50);
    tries = 0;
    quick = 1'b0;
    while (!quick) begin
      if (kind == GK_NOISE && tries < 4) begin
        for (i = 0; i < N_CELLS; i++)
          next_grid[i] = ($urandom_range(0, 3) == 0) ? cell_t'(0)
                                                     : cell_t'($urandom_range(1, 15));
      end else begin
        make_solution();
        for (i = 0; i < N_CELLS; i++) next_grid[i] = sol_grid[i];
        k = $urandom_range(1, kmax);
        repeat (k) next_grid[$urandom_range(0, N_CELLS - 1)] = '0;
        for (i = 0; i < N_CELLS; i++)
          if (next_grid[i] != '0 && $urandom_range(0, 23) == 0)
            next_grid[i] = cell_t'(OVERFLOW_VAL + $urandom_range(0, 5));
        if (kind == GK_BROKEN) begin
          // one stray given: usually a clash, sometimes harmless
          p            = $urandom_range(0, N_CELLS - 1);
          next_grid[p] = cell_t'($urandom_range(1, MAX_VAL));
        end
        kmax = kmax / 2 + 1;
      end
      tries++;
      grid_is_quick(quick);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Near-full grid with the first and last cells empty and 10/15 as givens.
  task automatic test_sparse_edges();
    int i;
    idle_on = 1'b1;
    make_solution();
    for (i = 0; i < N_CELLS; i++) next_grid[i] = sol_grid[i];
    repeat (10) next_grid[$urandom_range(1, N_CELLS - 2)] = '0;
    next_grid[13]          = cell_t'(OVERFLOW_VAL);
    next_grid[67]          = cell_t'(15);
    next_grid[0]           = '0;
    next_grid[N_CELLS - 1] = '0;
    send_grid();
  endtask

  // First cell can take no value: row holds 1..8, column holds 9. The search
  // backs up past the first cell at once. Bottom row of clashing nines.
  task automatic test_dead_first_cell();
    int i;
    idle_on = 1'b1;
    for (i = 0; i < N_CELLS; i++) next_grid[i] = '0;
    for (i = 1; i < N_COLS; i++) next_grid[i] = cell_t'(i);
    next_grid[4 * N_COLS] = cell_t'(MAX_VAL);
    for (i = 0; i < N_COLS; i++) next_grid[8 * N_COLS + i] = cell_t'(MAX_VAL);
    send_grid();
  endtask

  // No empty cells, full of clashes and 10..15: must come back unchanged.
  task automatic test_full_grid_passthrough();
    int i;
    idle_on = 1'b1;
    for (i = 0; i < N_CELLS; i++) next_grid[i] = cell_t'((i * 7) % 15 + 1);
    send_grid();
  endtask

  task automatic test_random_puzzles(input int n);
    repeat (n) begin
      idle_on = ($urandom_range(0, 3) != 0);
      build_grid(GK_PUZZLE);
      send_grid();
    end
  endtask

  task automatic test_broken_grids(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      idle_on = ($urandom_range(0, 1) != 0);
      build_grid((i % 2) ? GK_NOISE : GK_BROKEN);
      send_grid();
    end
  endtask

  // Closing stretch: rows offered every cycle, no gaps, taken whenever the block is not busy.
  task automatic test_back_to_back(input int n);
    idle_on = 1'b0;
    repeat (n) begin
      build_grid(GK_PUZZLE);
      send_grid();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every strobe is a result transaction, compared against
  // the oldest queued row. Outputs are read at the rising edge, before the
  // block's own updates for that edge land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    row_result_t want;
    int          j;
    if (!rst && strobe === 1'b1) begin
      if (solved_rows.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        want = solved_rows.pop_front();
        for (j = 0; j < N_COLS; j++)
          if (seen_cells[j] !== want.cells[j])
            report_mismatch($sformatf("grid %0d out_c%0d got %0d want %0d",
                                      grids_done, j, seen_cells[j], want.cells[j]));
        if (status !== want.status)
          report_mismatch($sformatf("grid %0d status got %0b want %0b",
                                    grids_done, status, want.status));
        if (last_row !== want.is_last)
          report_mismatch($sformatf("grid %0d last_row got %0b want %0b",
                                    grids_done, last_row, want.is_last));
        rows_checked++;
      end
    end
  end

  // Watchdog: cycles in which neither a row nor a result changes hands.
  always @(posedge clk) begin
    if ((start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: %0d cycles without a transaction", WATCHDOG);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_sparse_edges();
    test_dead_first_cell();
    test_full_grid_passthrough();
    test_random_puzzles(4);
    test_broken_grids(3);
    test_back_to_back(2);

    @(negedge clk);
    start <= 1'b0;
    while (solved_rows.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Ran %0d grids: %0d solved, %0d with no solution; %0d result rows checked.",
             grids_done, solved_grids, dead_grids, rows_checked);
    $display("Covered edge blanks, dead first cell, passthrough, random/broken/noise grids.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sbs_pkg.sv
rtl/sbs_lane.sv
rtl/sbs_merge.sv
rtl/sudoku_backtrack_solver.sv
rtl/sbs_checker.sv
sim/tb_sudoku_backtrack_solver.sv
